// ===== hw/rtl/gbn_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package gbn_pkg;

   localparam int RecordBytes = 512;
   localparam int Window      = 8;

   localparam int SeqW     = 16;
   localparam int SizeW    = 24;
   localparam int CountW   = 10;
   localparam int OffRawW  = SeqW + $clog2(RecordBytes + 1);
   localparam int OffW     = (OffRawW > SizeW + 1) ? OffRawW : SizeW + 1;
   localparam int WinW     = $clog2(Window + 1);

   localparam logic [1:0] KIND_START   = 2'd0;
   localparam logic [1:0] KIND_ACK     = 2'd1;
   localparam logic [1:0] KIND_NAK     = 2'd2;
   localparam logic [1:0] KIND_TIMEOUT = 2'd3;

   localparam logic RESULT_SEND   = 1'b0;
   localparam logic RESULT_FINISH = 1'b1;

   typedef struct packed {
      logic start;
      logic ack;
      logic nak;
      logic prep;
      logic emit;
   } gbn_cmd_type;

   typedef struct packed {
      logic active;
      logic ack_gt;
      logic ack_hits_last;
      logic out_free;
      logic item_last;
   } gbn_status_type;

endpackage

`default_nettype wire

// ===== hw/rtl/go_back_n_sender_window.sv =====
// Go-Back-N sender window. Write the transfer size to csr_wr_data (csr_wr_en) while idle,
// then send events on req: tuser is the event (0 start, 1 ack, 2 nak, 3 timeout), tdata the
// ack sequence. A start, a nak or timeout while active, or an ack (while active) above the
// acked sequence that reaches the last sent one yields a run of packet descriptors (sequence
// from the acked one plus 1, byte offset, byte count; the last record is short, and a size
// that is a whole number of records ends with an empty one) or a single finished item (tuser
// 1, data zero); tlast marks the end of the run. Other events give no item. An event is
// taken only when the block is idle; an event that sends then loads the window base and
// gives up to Window results from the window walk, one per cycle while rsp is ready.
`timescale 1ns / 1ps
`default_nettype none

module go_back_n_sender_window
   import gbn_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_wr_en,
   input  wire logic [SizeW-1:0]  csr_wr_data,   // file_size
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [15:0]       req_tdata,     // [15:0] ack_seq
   input  wire logic [1:0]        req_tuser,     // [1:0] kind
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic [55:0]            rsp_tdata,     // [15:0] seq_number, [39:16] byte_offset,
                                                 // [49:40] byte_count, [55:50] zero
   output logic                   rsp_tuser,     // [0] result_kind
   output logic                   rsp_tlast      // last_of_run
);

   gbn_cmd_type       cmd;
   gbn_status_type    status;
   logic [SeqW-1:0]   rsp_seq;
   logic [SizeW-1:0]  rsp_offset;
   logic [CountW-1:0] rsp_count;

   gbn_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_kind   (req_tuser),
      .status     (status),
      .req_tready (req_tready),
      .cmd        (cmd)
   );

   gbn_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_ack_seq (req_tdata),
      .cmd         (cmd),
      .rsp_tready  (rsp_tready),
      .status      (status),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_kind    (rsp_tuser),
      .rsp_seq     (rsp_seq),
      .rsp_offset  (rsp_offset),
      .rsp_count   (rsp_count),
      .rsp_last    (rsp_tlast)
   );

   assign rsp_tdata = {6'd0, rsp_count, rsp_offset, rsp_seq};

endmodule

`default_nettype wire

// ===== hw/rtl/gbn_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gbn_ctrl
   import gbn_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_tvalid,
   input  wire logic [1:0]     req_kind,
   input  wire gbn_status_type status,
   output logic                req_tready,
   output gbn_cmd_type         cmd
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_PREP = 2'd1;
   localparam logic [1:0] S_EMIT = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               unique case (req_kind)
                  KIND_START: begin
                     cmd.start = 1'b1;
                     state_in  = S_PREP;
                  end
                  KIND_ACK: begin
                     if (status.active && status.ack_gt) begin
                        cmd.ack = 1'b1;
                        if (status.ack_hits_last) begin
                           state_in = S_PREP;
                        end
                     end
                  end
                  KIND_NAK: begin
                     if (status.active) begin
                        cmd.nak  = 1'b1;
                        state_in = S_PREP;
                     end
                  end
                  KIND_TIMEOUT: begin
                     if (status.active) begin
                        state_in = S_PREP;
                     end
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_PREP: begin
            cmd.prep = 1'b1;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               if (status.item_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/gbn_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gbn_datapath
   import gbn_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_wr_en,
   input  wire logic [SizeW-1:0]   csr_wr_data,
   input  wire logic [SeqW-1:0]    req_ack_seq,
   input  wire gbn_cmd_type        cmd,
   input  wire logic               rsp_tready,
   output gbn_status_type          status,
   output logic                    rsp_tvalid,
   output logic                    rsp_kind,
   output logic [SeqW-1:0]         rsp_seq,
   output logic [SizeW-1:0]        rsp_offset,
   output logic [CountW-1:0]       rsp_count,
   output logic                    rsp_last
);

   localparam logic [OffW-1:0] RecStep = OffW'(RecordBytes);
   localparam logic [WinW-1:0] LastN   = WinW'(Window - 1);

   logic [SizeW-1:0]  fs_ff;
   logic [SeqW-1:0]   acked_ff;
   logic [SeqW-1:0]   last_sent_ff;
   logic              active_ff;
   logic [SeqW-1:0]   seq_ff;
   logic [OffW-1:0]   off_ff;
   logic [WinW-1:0]   n_ff;
   logic              first_ff;

   logic              out_valid_ff;
   logic              out_kind_ff;
   logic [SeqW-1:0]   out_seq_ff;
   logic [SizeW-1:0]  out_off_ff;
   logic [CountW-1:0] out_cnt_ff;
   logic              out_last_ff;

   logic [OffW-1:0]   fs_ext;
   logic [OffW-1:0]   next_off;
   logic [OffW-1:0]   remain;
   logic [OffW-1:0]   cnt_full;
   logic              finish_now;
   logic              last_desc;
   logic              out_free;

   assign fs_ext     = OffW'(fs_ff);
   assign next_off   = off_ff + RecStep;
   assign remain     = fs_ext - off_ff;
   assign cnt_full   = (remain > RecStep) ? RecStep : remain;
   assign finish_now = first_ff && ((off_ff > fs_ext) || (acked_ff == '1));
   assign last_desc  = (n_ff == LastN) || (next_off > fs_ext) || (seq_ff == '1);
   assign out_free   = !out_valid_ff || rsp_tready;

   assign status.active        = active_ff;
   assign status.ack_gt        = req_ack_seq > acked_ff;
   assign status.ack_hits_last = req_ack_seq == last_sent_ff;
   assign status.out_free      = out_free;
   assign status.item_last     = finish_now || last_desc;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_kind   = out_kind_ff;
   assign rsp_seq    = out_seq_ff;
   assign rsp_offset = out_off_ff;
   assign rsp_count  = out_cnt_ff;
   assign rsp_last   = out_last_ff;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         fs_ff        <= '0;
         acked_ff     <= '0;
         last_sent_ff <= '0;
         active_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            fs_ff <= csr_wr_data;
         end
         if (cmd.start) begin
            acked_ff  <= '0;
            active_ff <= 1'b1;
         end else if (cmd.ack) begin
            acked_ff <= req_ack_seq;
         end else if (cmd.nak) begin
            acked_ff <= (req_ack_seq == '0) ? '0 : req_ack_seq - 1'b1;
         end
         if (cmd.emit) begin
            out_valid_ff <= 1'b1;
            if (finish_now) begin
               active_ff <= 1'b0;
            end else if (last_desc) begin
               last_sent_ff <= seq_ff;
            end
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // window walk and output payload
   always_ff @(posedge clock) begin
      if (cmd.prep) begin
         seq_ff   <= acked_ff + 1'b1;
         off_ff   <= OffW'(acked_ff) * RecStep;
         n_ff     <= '0;
         first_ff <= 1'b1;
      end else if (cmd.emit) begin
         seq_ff   <= seq_ff + 1'b1;
         off_ff   <= next_off;
         n_ff     <= n_ff + 1'b1;
         first_ff <= 1'b0;
      end
      if (cmd.emit) begin
         if (finish_now) begin
            out_kind_ff <= RESULT_FINISH;
            out_seq_ff  <= '0;
            out_off_ff  <= '0;
            out_cnt_ff  <= '0;
            out_last_ff <= 1'b1;
         end else begin
            out_kind_ff <= RESULT_SEND;
            out_seq_ff  <= seq_ff;
            out_off_ff  <= off_ff[SizeW-1:0];
            out_cnt_ff  <= cnt_full[CountW-1:0];
            out_last_ff <= last_desc;
         end
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/gbn_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gbn_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [55:0] rsp_tdata,
   input wire logic        rsp_tuser,
   input wire logic        rsp_tlast
);

   // hold a stalled item
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp item changed while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("finished item not at end of run");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == 56'd0)
      else $error("finished item carries data");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[15:0] != 16'd0)
      else $error("descriptor with sequence zero");

endmodule

bind go_back_n_sender_window gbn_checker u_gbn_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire
